// ===== rtl/efd_pkg.sv =====
// shared types and constants of the escaped frame delimiter
package efd_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'd241;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'd242;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd243;

   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 2'd2;

   typedef enum logic [2:0] {
      ST_CAPTURE = 3'b001,
      ST_FETCH   = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   typedef struct packed {
      logic take;
      logic fetch;
      logic advance;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic complete;
      logic last;
   } status_type;

endpackage

// ===== rtl/efd_ram.sv =====
// generic single write port ram with registered read
module efd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/efd_ctrl.sv =====
// controller state machine for capture and replay
module efd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  efd_pkg::status_type sts,
   output efd_pkg::cmd_type    cmd
);

   efd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      unique case (state_ff)
         efd_pkg::ST_CAPTURE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && sts.complete) begin
               state_in = efd_pkg::ST_FETCH;
            end
         end
         efd_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = efd_pkg::ST_EMIT;
         end
         efd_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.last) begin
                  cmd.finish = 1'b1;
                  state_in   = efd_pkg::ST_CAPTURE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = efd_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = efd_pkg::ST_CAPTURE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efd_pkg::ST_CAPTURE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/efd_datapath.sv =====
// marker registers, frame detection, frame store and replay datapath
module efd_datapath #(
   parameter int MAX_FRAME = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [efd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [efd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [efd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   input  logic [efd_pkg::BYTE_W-1:0]           rx_byte,
   input  efd_pkg::cmd_type                     cmd,
   output efd_pkg::status_type                  sts,
   output logic [efd_pkg::BYTE_W-1:0]           frame_byte,
   output logic [efd_pkg::LEN_W-1:0]            frame_length,
   output logic                                 truncated
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam logic [efd_pkg::LEN_W-1:0] MAX_LEN = efd_pkg::LEN_W'(MAX_FRAME);

   logic [efd_pkg::BYTE_W-1:0] start_ff, end_ff, esc_ff, prev_ff;
   logic                       in_frame_ff, in_frame_in;
   logic                       ovf_ff, ovf_in;
   logic [efd_pkg::LEN_W-1:0]  fill_ff, fill_in;
   logic [AW-1:0]              rd_idx_ff, rd_idx_in;

   logic                       csr_wr;
   logic [efd_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                       escaped, is_start, is_end, restart, store, room;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [efd_pkg::LEN_W-1:0]  next_idx;

   // configuration registers
   assign csr_idx = csr_paddr[efd_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= efd_pkg::START_RESET;
         end_ff   <= efd_pkg::END_RESET;
         esc_ff   <= efd_pkg::ESCAPE_RESET;
      end else if (csr_wr) begin
         if (csr_idx == efd_pkg::CSR_START) begin
            start_ff <= csr_pwdata[efd_pkg::BYTE_W-1:0];
         end
         if (csr_idx == efd_pkg::CSR_END) begin
            end_ff <= csr_pwdata[efd_pkg::BYTE_W-1:0];
         end
         if (csr_idx == efd_pkg::CSR_ESCAPE) begin
            esc_ff <= csr_pwdata[efd_pkg::BYTE_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_idx)
         efd_pkg::CSR_START:  csr_prdata = efd_pkg::CSR_DATA_W'(start_ff);
         efd_pkg::CSR_END:    csr_prdata = efd_pkg::CSR_DATA_W'(end_ff);
         efd_pkg::CSR_ESCAPE: csr_prdata = efd_pkg::CSR_DATA_W'(esc_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // marker detection, start wins over end
   assign escaped  = (prev_ff == esc_ff);
   assign is_start = (rx_byte == start_ff);
   assign is_end   = !is_start && (rx_byte == end_ff);
   assign restart  = is_start && !escaped;
   assign store    = restart || in_frame_ff;
   assign room     = (fill_ff < MAX_LEN);

   assign sts.complete = is_end && in_frame_ff && !escaped;

   assign wr_en   = cmd.take && store && (restart || room);
   assign wr_addr = restart ? '0 : fill_ff[AW-1:0];

   always_comb begin
      in_frame_in = in_frame_ff;
      ovf_in      = ovf_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      if (cmd.take) begin
         if (restart) begin
            in_frame_in = 1'b1;
            ovf_in      = 1'b0;
            fill_in     = efd_pkg::LEN_W'(1);
         end else if (store) begin
            if (room) begin
               fill_in = fill_ff + efd_pkg::LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
      if (cmd.finish) begin
         in_frame_in = 1'b0;
         ovf_in      = 1'b0;
         fill_in     = '0;
         rd_idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         in_frame_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         fill_ff     <= '0;
         rd_idx_ff   <= '0;
      end else begin
         if (cmd.take) begin
            prev_ff <= rx_byte;
         end
         in_frame_ff <= in_frame_in;
         ovf_ff      <= ovf_in;
         fill_ff     <= fill_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   efd_ram #(
      .WIDTH (efd_pkg::BYTE_W),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_idx_ff),
      .rd_data (frame_byte)
   );

   assign next_idx     = efd_pkg::LEN_W'(rd_idx_ff) + efd_pkg::LEN_W'(1);
   assign sts.last     = (next_idx == fill_ff);
   assign frame_length = fill_ff;
   assign truncated    = ovf_ff;

endmodule

// ===== rtl/escaped_frame_delimiter_unit.sv =====
// Escaped frame delimiter: takes one received byte per cycle while capturing and
// stores every byte from an unescaped start marker up to an unescaped end marker,
// markers and escape bytes included, in a MAX_FRAME-deep store; bytes beyond the
// store are dropped and the frame is flagged truncated. A byte is escaped when the
// byte before it equals the escape marker. On a real end marker the input stalls
// and the frame is replayed: each stored byte is first read from the store through
// its registered read port and then presented as the word, and the input is held
// off until the last byte has been taken, including any output back-pressure.
// Marker values are set through the register port at byte addresses 0, 4 and 8.
module escaped_frame_delimiter_unit #(
   parameter int MAX_FRAME = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // frame_byte, frame_length, zero pad
   output logic                            rsp_tlast,
   output logic [0:0]                      rsp_tuser,   // truncated
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [efd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [efd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [efd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   efd_pkg::cmd_type           cmd;
   efd_pkg::status_type        sts;
   logic [efd_pkg::BYTE_W-1:0] frame_byte;
   logic [efd_pkg::LEN_W-1:0]  frame_length;
   logic                       truncated;

   assign csr_pready = 1'b1;

   efd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   efd_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .rx_byte      (req_tdata),
      .cmd          (cmd),
      .sts          (sts),
      .frame_byte   (frame_byte),
      .frame_length (frame_length),
      .truncated    (truncated)
   );

   assign rsp_tdata = {1'b0, frame_length, frame_byte};
   assign rsp_tlast = sts.last;
   assign rsp_tuser = truncated;

endmodule
